// File: hdl/clb_pkg.sv
// ----------------------------------------------------------------------------
// clb_pkg
// Shared constants and types for the comment and literal blanker.
// ----------------------------------------------------------------------------
package clb_pkg;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Results produced by one request: count is 0, 1 or 2, byte0 goes first.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } t_scan_res;

    // One queued result.
    typedef struct packed {
        logic [7:0] clean_byte;
        logic       last_of_run;
    } t_out_entry;

endpackage

// File: hdl/clb_scanner.sv
// ----------------------------------------------------------------------------
// clb_scanner
// Scan state (mode, escape flag) and the per-byte decode that yields up to
// two result bytes and the next state.
// ----------------------------------------------------------------------------
module clb_scanner
    import clb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output t_scan_res  o_res
);

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_HELD       = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4,
        MODE_STRING     = 3'd5,
        MODE_CHAR       = 3'd6
    } t_mode;

    t_mode r_mode, n_mode;
    logic  r_esc, n_esc;

    t_mode      rest_mode;
    logic       rest_emit;
    logic [7:0] rest_byte;
    t_mode      rest_next;
    logic       rest_esc;

    // Handle the byte in rest_mode (held slash already resolved).
    always_comb begin
        rest_mode = (r_mode == MODE_HELD) ? MODE_NORMAL : r_mode;
        rest_emit = 1'b1;
        rest_byte = CH_SPACE;
        rest_next = rest_mode;
        rest_esc  = r_esc;
        if (i_text_byte == CH_NEWLINE) begin
            rest_byte = CH_NEWLINE;
            rest_esc  = 1'b0;
            if (rest_mode == MODE_LINE) begin
                rest_next = MODE_NORMAL;
            end else if (rest_mode == MODE_BLOCK_STAR) begin
                rest_next = MODE_BLOCK;
            end
        end else begin
            case (rest_mode)
                MODE_LINE: begin
                    rest_next = MODE_LINE;
                end
                MODE_BLOCK: begin
                    if (i_text_byte == CH_STAR) begin
                        rest_next = MODE_BLOCK_STAR;
                    end
                end
                MODE_BLOCK_STAR: begin
                    if (i_text_byte == CH_SLASH) begin
                        rest_next = MODE_NORMAL;
                    end else if (i_text_byte != CH_STAR) begin
                        rest_next = MODE_BLOCK;
                    end
                end
                MODE_STRING, MODE_CHAR: begin
                    if (r_esc) begin
                        rest_esc = 1'b0;
                    end else if (i_text_byte == CH_BACKSLASH) begin
                        rest_esc = 1'b1;
                    end else if ((rest_mode == MODE_STRING && i_text_byte == CH_DQUOTE) ||
                                 (rest_mode == MODE_CHAR && i_text_byte == CH_SQUOTE)) begin
                        rest_next = MODE_NORMAL;
                    end
                end
                default: begin
                    // normal code, and the unused mode code
                    rest_next = MODE_NORMAL;
                    if (i_text_byte == CH_SLASH) begin
                        if (i_end_of_text) begin
                            rest_byte = CH_SLASH;
                        end else begin
                            rest_emit = 1'b0;
                            rest_next = MODE_HELD;
                        end
                    end else if (i_text_byte == CH_DQUOTE) begin
                        rest_next = MODE_STRING;
                    end else if (i_text_byte == CH_SQUOTE) begin
                        rest_next = MODE_CHAR;
                    end else begin
                        rest_byte = i_text_byte;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res.byte1 = rest_byte;
        n_esc       = rest_esc;
        if (r_mode == MODE_HELD &&
            (i_text_byte == CH_SLASH || i_text_byte == CH_STAR)) begin
            o_res.count = 2'd2;
            o_res.byte0 = CH_SPACE;
            o_res.byte1 = CH_SPACE;
            n_mode      = (i_text_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            n_esc       = r_esc;
        end else if (r_mode == MODE_HELD) begin
            // flush the held slash ahead of this byte's own result
            o_res.count = rest_emit ? 2'd2 : 2'd1;
            o_res.byte0 = CH_SLASH;
            n_mode      = rest_next;
        end else begin
            o_res.count = rest_emit ? 2'd1 : 2'd0;
            o_res.byte0 = rest_byte;
            n_mode      = rest_next;
        end
        // end of text returns everything to reset state
        if (i_end_of_text) begin
            n_mode = MODE_NORMAL;
            n_esc  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_esc  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
        end
    end

endmodule

// File: hdl/clb_out_queue.sv
// ----------------------------------------------------------------------------
// clb_out_queue
// Four-entry result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module clb_out_queue
    import clb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_scan_res  i_res,
    input  logic       i_pop,
    output logic       o_valid,
    output t_out_entry o_entry,
    output logic       o_room2
);

    t_out_entry r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic [1:0] push_cnt;
    logic       pop_go;

    assign o_valid  = (r_count != 3'd0);
    assign o_entry  = r_mem[r_rd_ptr];
    assign o_room2  = (r_count <= 3'd2);
    assign push_cnt = i_push ? i_res.count : 2'd0;
    assign pop_go   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_cnt;
        n_rd_ptr = r_rd_ptr + {1'b0, pop_go};
        n_count  = r_count + {1'b0, push_cnt} - {2'b00, pop_go};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // the last result of a request carries last_of_run
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr].clean_byte  <= i_res.byte0;
            r_mem[r_wr_ptr].last_of_run <= (push_cnt == 2'd1);
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1].clean_byte  <= i_res.byte1;
            r_mem[r_wr_ptr + 2'd1].last_of_run <= 1'b1;
        end
    end

endmodule

// File: hdl/comment_literal_blanker_top.sv
// ----------------------------------------------------------------------------
// comment_literal_blanker_top
// Blanks C/C++ comments and literals in a byte stream.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle and returns it, or a space when it lies in a
// comment, string or character literal; newlines always pass. A '/' in code is
// held until the next byte shows whether it opens a comment, so a request makes
// zero, one or two results, and last_of_run marks the final one. Results go
// through a four-entry queue, read one per cycle unless the output stalls: a
// request is taken every cycle while the queue has room for two, and a
// two-result request uses two entries. There is no start-up sweep after reset.
module comment_literal_blanker_top
    import clb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_clean_byte,
    output logic       o_last_of_run
);

    t_scan_res  scan_res;
    t_out_entry head;
    logic       room2;
    logic       accept;

    assign o_stall = !room2;
    assign accept  = i_valid && room2;

    clb_scanner u_scanner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_res         (scan_res)
    );

    clb_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (scan_res),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_entry (head),
        .o_room2 (room2)
    );

    assign o_clean_byte  = head.clean_byte;
    assign o_last_of_run = head.last_of_run;

endmodule

// File: bench/clb_checker.sv
// ----------------------------------------------------------------------------
// clb_checker
// Scoreboard for the comment and literal blanker.
// ----------------------------------------------------------------------------
// Watches both channels. Every accepted request runs through a scan model
// that keeps its own copy of the scanner state and queues the blanked bytes
// that the request should produce. Every accepted result is checked against
// the oldest queued byte, field by field.
// ----------------------------------------------------------------------------
module clb_checker
    import clb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [7:0] i_clean_byte,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_outstanding,
    output int         o_results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 40;

    typedef enum logic [2:0] {
        SCAN_CODE,
        SCAN_SLASH_HELD,
        SCAN_LINE_CMT,
        SCAN_BLOCK_CMT,
        SCAN_BLOCK_STAR,
        SCAN_STRING,
        SCAN_CHAR
    } t_scan_mode;

    t_scan_mode  scan_mode = SCAN_CODE;
    logic        esc_pending = 1'b0;
    t_out_entry  blanked_q[$];
    int          mismatch_count = 0;
    int          checked_count = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Advance the scan model by one request and queue the bytes it yields.
    task automatic predict_blanked(input logic [7:0] c, input logic eot);
        logic [7:0] outb [2];
        int         n;
        logic       taken;
        t_out_entry ent;
        n = 0;
        taken = 1'b0;

        if (scan_mode == SCAN_SLASH_HELD) begin
            if (c == CH_SLASH || c == CH_STAR) begin
                outb[0] = CH_SPACE;
                outb[1] = CH_SPACE;
                n = 2;
                taken = 1'b1;
                scan_mode = (c == CH_SLASH) ? SCAN_LINE_CMT : SCAN_BLOCK_CMT;
            end else begin
                // flush the held slash, then treat this byte as code
                outb[0] = CH_SLASH;
                n = 1;
                scan_mode = SCAN_CODE;
            end
        end

        if (!taken) begin
            if (c == CH_NEWLINE) begin
                outb[n] = CH_NEWLINE;
                n++;
                if (scan_mode == SCAN_LINE_CMT)
                    scan_mode = SCAN_CODE;
                else if (scan_mode == SCAN_BLOCK_STAR)
                    scan_mode = SCAN_BLOCK_CMT;
                esc_pending = 1'b0;
            end else begin
                case (scan_mode)
                    SCAN_LINE_CMT: begin
                        outb[n] = CH_SPACE;
                        n++;
                    end
                    SCAN_BLOCK_CMT: begin
                        outb[n] = CH_SPACE;
                        n++;
                        if (c == CH_STAR)
                            scan_mode = SCAN_BLOCK_STAR;
                    end
                    SCAN_BLOCK_STAR: begin
                        outb[n] = CH_SPACE;
                        n++;
                        if (c == CH_SLASH)
                            scan_mode = SCAN_CODE;
                        else if (c != CH_STAR)
                            scan_mode = SCAN_BLOCK_CMT;
                    end
                    SCAN_STRING, SCAN_CHAR: begin
                        outb[n] = CH_SPACE;
                        n++;
                        if (esc_pending)
                            esc_pending = 1'b0;
                        else if (c == CH_BACKSLASH)
                            esc_pending = 1'b1;
                        else if ((scan_mode == SCAN_STRING && c == CH_DQUOTE) ||
                                 (scan_mode == SCAN_CHAR && c == CH_SQUOTE))
                            scan_mode = SCAN_CODE;
                    end
                    default: begin
                        if (c == CH_SLASH) begin
                            // a slash on the last byte cannot open a comment
                            if (eot) begin
                                outb[n] = CH_SLASH;
                                n++;
                            end else begin
                                scan_mode = SCAN_SLASH_HELD;
                            end
                        end else if (c == CH_DQUOTE) begin
                            outb[n] = CH_SPACE;
                            n++;
                            scan_mode = SCAN_STRING;
                        end else if (c == CH_SQUOTE) begin
                            outb[n] = CH_SPACE;
                            n++;
                            scan_mode = SCAN_CHAR;
                        end else begin
                            outb[n] = c;
                            n++;
                        end
                    end
                endcase
            end
        end

        for (int k = 0; k < n; k++) begin
            ent.clean_byte  = outb[k];
            ent.last_of_run = (k == n - 1);
            blanked_q.insert(blanked_q.size(), ent);
        end

        if (eot) begin
            scan_mode = SCAN_CODE;
            esc_pending = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_entry want;
        if (!i_rst_n) begin
            scan_mode = SCAN_CODE;
            esc_pending = 1'b0;
            blanked_q.delete();
        end else begin
            if (i_req_valid && !i_req_stall)
                predict_blanked(i_text_byte, i_end_of_text);
            if (i_res_valid && !i_res_stall) begin
                if (blanked_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d: byte %h with nothing expected",
                                              checked_count, i_clean_byte));
                end else begin
                    want = blanked_q.pop_front();
                    if (i_clean_byte !== want.clean_byte)
                        report_mismatch($sformatf("result %0d: clean_byte %h, expected %h",
                                                  checked_count, i_clean_byte,
                                                  want.clean_byte));
                    if (i_last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("result %0d: last_of_run %b, expected %b",
                                                  checked_count, i_last_of_run,
                                                  want.last_of_run));
                end
                checked_count++;
            end
        end
        o_fail_count = mismatch_count;
        o_outstanding = blanked_q.size();
        o_results_checked = checked_count;
    end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the comment and literal blanker.
// ----------------------------------------------------------------------------
// Feeds a short directed text that touches every scanner mode and the corner
// cases around held slashes, escapes and end of text, then about 1500 bytes
// of random C-like fragments with noise and random ends of text. Both sides
// idle at random; once the output is held off long enough for the block to
// fill up and stall its input. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import clb_pkg::*;

    localparam int RANDOM_BYTES    = 1500;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int IDLE_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 32;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_text_byte;
    logic       i_end_of_text;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_clean_byte;
    logic       o_last_of_run;

    int   fail_count;
    int   outstanding;
    int   results_checked;
    int   sent_count = 0;
    int   eot_count = 0;
    int   idle_cycles = 0;
    logic tx_eager = 1'b0;
    logic rx_eager = 1'b0;
    logic hold_off_req = 1'b0;

    comment_literal_blanker_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_clean_byte  (o_clean_byte),
        .o_last_of_run (o_last_of_run)
    );

    clb_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_valid),
        .i_req_stall       (o_stall),
        .i_text_byte       (i_text_byte),
        .i_end_of_text     (i_end_of_text),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_clean_byte      (o_clean_byte),
        .i_last_of_run     (o_last_of_run),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_results_checked (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: draw a hold-off per result, plus one long hold-off on request.
    initial begin
        int gap;
        int hold_cycles;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_stall = 1'b1;
                hold_cycles = 0;
                while (hold_cycles < HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    hold_cycles++;
                end
                hold_off_req = 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                rx_eager = !rx_eager;
            gap = rx_eager ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                i_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_text_byte = b;
        i_end_of_text = eot;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (eot)
            eot_count++;
        @(negedge i_clk);
    endtask

    // Random bytes end the text now and then, which breaks fragments midway.
    task automatic put_byte(input logic [7:0] b);
        send_request(b, $urandom_range(0, 79) == 0);
    endtask

    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 11))
            0: return CH_STAR;
            1: return CH_SLASH;
            2: return CH_DQUOTE;
            3: return CH_SQUOTE;
            4: return CH_BACKSLASH;
            5: return CH_NEWLINE;
            6: return CH_SPACE;
            7: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    task automatic send_fragment();
        case ($urandom_range(0, 9))
            0: begin
                put_byte(CH_DQUOTE);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 3) == 0)
                        put_byte(CH_BACKSLASH);
                    put_byte(body_byte());
                end
                put_byte(CH_DQUOTE);
            end
            1: begin
                put_byte(CH_SQUOTE);
                if ($urandom_range(0, 2) == 0)
                    put_byte(CH_BACKSLASH);
                put_byte(body_byte());
                put_byte(CH_SQUOTE);
            end
            2: begin
                put_byte(CH_SLASH);
                put_byte(CH_SLASH);
                repeat ($urandom_range(0, 8)) put_byte(body_byte());
                put_byte(CH_NEWLINE);
            end
            3: begin
                put_byte(CH_SLASH);
                put_byte(CH_STAR);
                repeat ($urandom_range(0, 10)) put_byte(body_byte());
                put_byte(CH_STAR);
                put_byte(CH_SLASH);
            end
            4: begin
                put_byte(CH_SLASH);
                put_byte(8'($urandom_range(0, 255)));
            end
            5: put_byte(CH_NEWLINE);
            6: repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
            default: repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(8'h21, 8'h7E)));
        endcase
    endtask

    initial begin
        // {end_of_text, byte}
        logic [8:0] opening [] = '{
            {1'b0, 8'h61}, {1'b0, 8'h00}, {1'b0, 8'hFF},
            // line comment closed by newline
            {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, 8'h63}, {1'b0, CH_NEWLINE},
            // block comment: star then newline forgets the star
            {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_STAR}, {1'b0, CH_NEWLINE},
            {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},
            // string with escaped quote, newline inside the literal
            {1'b0, CH_DQUOTE}, {1'b0, CH_BACKSLASH}, {1'b0, CH_DQUOTE},
            {1'b0, CH_NEWLINE}, {1'b0, CH_DQUOTE},
            // character literal with escaped quote
            {1'b0, CH_SQUOTE}, {1'b0, CH_BACKSLASH}, {1'b0, CH_SQUOTE}, {1'b0, CH_SQUOTE},
            // held slash flushed by newline, slash on the last byte
            {1'b0, CH_SLASH}, {1'b0, CH_NEWLINE}, {1'b1, CH_SLASH},
            // text ends inside a string
            {1'b0, CH_DQUOTE}, {1'b1, 8'h7A}
        };
        logic pressure_started;
        int   random_start;
        pressure_started = 1'b0;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_text_byte = '0;
        i_end_of_text = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (opening[k])
            send_request(opening[k][7:0], opening[k][8]);

        random_start = sent_count;
        while (sent_count < random_start + RANDOM_BYTES) begin
            if (!pressure_started && sent_count >= random_start + 400) begin
                hold_off_req = 1'b1;
                pressure_started = 1'b1;
            end
            // keep offering back to back while the output is held off
            if (hold_off_req)
                tx_eager = 1'b1;
            else if ($urandom_range(0, 15) == 0)
                tx_eager = !tx_eager;
            send_fragment();
        end
        i_valid = 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d source bytes with %0d ends of text; checked %0d output bytes.",
                 sent_count, eot_count, results_checked);
        $display("Mix: comments, literals with escapes, held slashes, raw bytes, %0d-cycle %s",
                 HOLD_OFF_CYCLES, "output hold-off");
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
